// ===== rtl/sfh_pkg.sv =====
// Package for the SuperFastHash streaming block: constants and mixing functions.
package sfh_pkg;

  localparam logic [31:0] MAX_MESSAGE_BYTES = 32'd65535;

  localparam int unsigned SHIFT_TAIL_LO = 11;
  localparam int unsigned SHIFT_HALF    = 16;
  localparam int unsigned SHIFT_TAIL_HI = 18;
  localparam int unsigned SHIFT_AV_17   = 17;
  localparam int unsigned SHIFT_TAIL_1  = 10;
  localparam int unsigned SHIFT_AV_25   = 25;

  typedef logic [31:0] hash_t;
  typedef logic [23:0] pend_t;
  typedef logic [1:0]  cnt_t;

  function automatic hash_t sext8(input logic [7:0] b);
    return {{24{b[7]}}, b};
  endfunction

  // Full four-byte group: low half from the buffer, high half from
  // buffered byte 2 and the incoming byte.
  function automatic hash_t group_mix(input hash_t h_in, input pend_t buf_in,
                                      input logic [7:0] byte_in);
    hash_t h;
    hash_t t;
    hash_t hi;
    hi = {16'd0, byte_in, buf_in[23:16]};
    h  = h_in + {16'd0, buf_in[15:0]};
    t  = (hi << SHIFT_TAIL_LO) ^ h;
    h  = (h << SHIFT_HALF) ^ t;
    h  = h + (h >> SHIFT_TAIL_LO);
    return h;
  endfunction

  // Tail rule for leftover bytes, then the first two avalanche steps.
  function automatic hash_t finish_lo(input hash_t h_in, input pend_t buf_in,
                                      input cnt_t cnt);
    hash_t h;
    h = h_in;
    case (cnt)
      2'd3: begin
        h = h + {16'd0, buf_in[15:0]};
        h = h ^ (h << SHIFT_HALF);
        h = h ^ (sext8(buf_in[23:16]) << SHIFT_TAIL_HI);
        h = h + (h >> SHIFT_TAIL_LO);
      end
      2'd2: begin
        h = h + {16'd0, buf_in[15:0]};
        h = h ^ (h << SHIFT_TAIL_LO);
        h = h + (h >> SHIFT_AV_17);
      end
      2'd1: begin
        h = h + sext8(buf_in[7:0]);
        h = h ^ (h << SHIFT_TAIL_1);
        h = h + (h >> 1);
      end
      default: begin
        h = h_in;
      end
    endcase
    h = h ^ (h << 3);
    h = h + (h >> 5);
    return h;
  endfunction

  // Last four avalanche steps.
  function automatic hash_t finish_hi(input hash_t h_in);
    hash_t h;
    h = h_in ^ (h_in << 4);
    h = h + (h >> SHIFT_AV_17);
    h = h ^ (h << SHIFT_AV_25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

// ===== rtl/superfast_string_hash.sv =====
// SuperFastHash of a byte stream, one byte per input beat.
//
// Input channel: in_valid / in_stall carry data_byte, carries_byte,
// last_byte and msg_length. msg_length of the first beat of a message
// seeds the hash. carries_byte low adds no byte (used for an empty message).
// The beat with last_byte high closes the message.
// Output channel: out_valid / out_stall carry hash_value, one beat per
// message.
// Throughput: one input beat per cycle while in_stall is low. The running
// hash is updated in the cycle a beat is taken; the group mix is one
// add-xor-add step. Finish path: hash_value is registered; the last beat
// lands in the first finish stage, then passes the second finish stage
// and the output register.
// Stall: a stalled output beat holds. Up to three finished messages sit in
// the finish pipe; in_stall rises only when the first finish stage is full
// and cannot drain.
// Reset (rst, synchronous): the block waits for the first beat of a message
// and the finish pipe and output are empty.
module superfast_string_hash (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           data_byte,
  input  logic                 carries_byte,
  input  logic                 last_byte,
  input  logic [15:0]          msg_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sfh_pkg::hash_t       hash_value
);
  import sfh_pkg::*;

  hash_t running_hash;
  pend_t pending_bytes;
  cnt_t  pending_count;
  logic  in_message;

  hash_t fin1_hash;
  pend_t fin1_bytes;
  cnt_t  fin1_count;
  logic  fin1_valid;
  hash_t fin2_hash;
  logic  fin2_valid;

  logic  accept;
  logic  out_ready;
  logic  fin2_ready;
  logic  fin1_ready;

  hash_t seed;
  hash_t hash_cur;
  pend_t bytes_cur;
  cnt_t  count_cur;
  hash_t running_hash_next;
  pend_t pending_bytes_next;
  cnt_t  pending_count_next;

  assign out_ready  = !out_valid || !out_stall;
  assign fin2_ready = !fin2_valid || out_ready;
  assign fin1_ready = !fin1_valid || fin2_ready;
  assign in_stall   = !fin1_ready;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    seed = ({16'd0, msg_length} > MAX_MESSAGE_BYTES) ? MAX_MESSAGE_BYTES
                                                     : {16'd0, msg_length};
    hash_cur  = in_message ? running_hash  : seed;
    bytes_cur = in_message ? pending_bytes : '0;
    count_cur = in_message ? pending_count : '0;
    running_hash_next  = hash_cur;
    pending_bytes_next = bytes_cur;
    pending_count_next = count_cur;
    if (carries_byte) begin
      if (count_cur == 2'd3) begin
        running_hash_next  = group_mix(hash_cur, bytes_cur, data_byte);
        pending_bytes_next = '0;
        pending_count_next = '0;
      end else begin
        case (count_cur)
          2'd0:    pending_bytes_next[7:0]   = data_byte;
          2'd1:    pending_bytes_next[15:8]  = data_byte;
          default: pending_bytes_next[23:16] = data_byte;
        endcase
        pending_count_next = count_cur + 2'd1;
      end
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message    <= 1'b0;
      pending_count <= '0;
    end else if (accept) begin
      in_message    <= !last_byte;
      pending_count <= last_byte ? '0 : pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      running_hash  <= running_hash_next;
      pending_bytes <= pending_bytes_next;
    end
  end

  // Finish pipe: tail + first avalanche steps, rest of avalanche, output
  always_ff @(posedge clk) begin
    if (rst) begin
      fin1_valid <= 1'b0;
      fin2_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fin1_ready) fin1_valid <= accept && last_byte;
      if (fin2_ready) fin2_valid <= fin1_valid;
      if (out_ready)  out_valid  <= fin2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin1_ready && accept && last_byte) begin
      fin1_hash  <= running_hash_next;
      fin1_bytes <= pending_bytes_next;
      fin1_count <= pending_count_next;
    end
    if (fin2_ready && fin1_valid) begin
      fin2_hash <= finish_lo(fin1_hash, fin1_bytes, fin1_count);
    end
    if (out_ready && fin2_valid) begin
      hash_value <= finish_hi(fin2_hash);
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> fin1_valid && fin2_valid && out_valid && out_stall)
    else $error("input stalled while finish pipe has room");

  a_last_closes_msg: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> !in_message && fin1_valid)
    else $error("last beat did not close message");

  a_beat_opens_msg: assert property (@(posedge clk) disable iff (rst)
    accept && !last_byte |=> in_message)
    else $error("non-last beat left block outside a message");

  a_pending_in_msg: assert property (@(posedge clk) disable iff (rst)
    pending_count != 2'd0 |-> in_message)
    else $error("buffered bytes outside a message");

  a_fin1_held: assert property (@(posedge clk) disable iff (rst)
    fin1_valid && !fin2_ready |=> fin1_valid && $stable(fin1_hash))
    else $error("finish stage lost a held message");
`endif

endmodule
